// ===== hdl/timed_priority_entry_table_macros.svh =====
// Assertion macros for the timed priority entry table.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef TIMED_PRIORITY_ENTRY_TABLE_MACROS_SVH
`define TIMED_PRIORITY_ENTRY_TABLE_MACROS_SVH
`ifndef SYNTH
`define TPET_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TPET_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TPET_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TPET_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/tpet_pkg.sv =====
// Shared types and codes of the timed priority entry table.
// No dependencies.
package tpet_pkg;

    localparam logic [2:0] OP_POST    = 3'd0;
    localparam logic [2:0] OP_DEL_ID  = 3'd1;
    localparam logic [2:0] OP_DEL_CAT = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_DEL_ALL = 3'd4;

    localparam logic [2:0] EV_POSTED    = 3'd0;
    localparam logic [2:0] EV_MUTED     = 3'd1;
    localparam logic [2:0] EV_EVICTED   = 3'd2;
    localparam logic [2:0] EV_EXPIRED   = 3'd3;
    localparam logic [2:0] EV_DISMISSED = 3'd4;
    localparam logic [2:0] EV_DONE      = 3'd5;

    localparam logic [2:0] CMD_POST    = 3'd0;
    localparam logic [2:0] CMD_MUTED   = 3'd1;
    localparam logic [2:0] CMD_DEL_ID  = 3'd2;
    localparam logic [2:0] CMD_DEL_CAT = 3'd3;
    localparam logic [2:0] CMD_TICK    = 3'd4;
    localparam logic [2:0] CMD_DEL_ALL = 3'd5;
    localparam logic [2:0] CMD_NOP     = 3'd6;

    localparam logic CFG_MAX_ACTIVE = 1'b0;
    localparam logic CFG_MUTE_MASK  = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  category;
        logic [1:0]  priority_req;
        logic [15:0] duration_ms;
        logic [15:0] target_id;
        logic [15:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [15:0] event_id;
        logic [3:0]  active_count;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  category;
        logic [1:0]  prio;
        logic [15:0] duration_ms;
        logic [15:0] target_id;
        logic [15:0] elapsed_ms;
    } t_cmd;

    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  category;
        logic [1:0]  prio;
        logic        persistent;
        logic [15:0] remaining_ms;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic cnt_ovf;
    } t_bk_stat;

endpackage

// ===== hdl/timed_priority_entry_table.sv =====
// Post: POST (eviction beat if the table is at its limit), INS (posted beat), DONE; muted
// posts give their beat in POST, then DONE; an unknown op goes to DONE. Removals: MARK, REM
// (one result beat per cycle unless the output stalls), DONE. Items are taken only in IDLE.
// The front queue holds two decoded items, so input is taken while the back is busy.
// Reset (synchronous, active low) empties table and queue, next id 1, max_active 5, mute 0.
module timed_priority_entry_table #(
    parameter int CAPACITY        = 8,
    parameter int NUM_CATEGORIES  = 8,
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  tpet_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output tpet_pkg::t_out_item o_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import tpet_pkg::*;
`include "timed_priority_entry_table_macros.svh"

    logic [3:0] r_max_active;
    logic [7:0] r_mute_mask;
    logic       cmd_valid, cmd_take;
    t_cmd       cmd;
    t_bk_stat   bk_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_active <= 4'd5;
            r_mute_mask  <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_ACTIVE: r_max_active <= i_cfg_data[3:0];
                CFG_MUTE_MASK:  r_mute_mask  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tpet_front #(
        .NUM_CATEGORIES (NUM_CATEGORIES),
        .PRIORITY_LEVELS(PRIORITY_LEVELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .i_mute_mask(r_mute_mask),
        .o_cmd_valid(cmd_valid),
        .i_cmd_take (cmd_take),
        .o_cmd      (cmd)
    );

    tpet_back #(
        .CAPACITY(CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_active(r_max_active),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .o_stat      (bk_stat)
    );

    `TPET_ASSERT_IMP(a_last_is_done, i_clk, i_rst_n, o_valid && o_item.last, o_item.event_kind == EV_DONE)
    `TPET_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, !bk_stat.cnt_ovf)
    `TPET_ASSERT_IMP(a_full_has_head, i_clk, i_rst_n, o_stall, cmd_valid)
    `TPET_ASSERT_NXT(a_take_starts, i_clk, i_rst_n, cmd_take && cmd_valid, bk_stat.busy)

endmodule

// ===== hdl/tpet_front.sv =====
// Front part: accepts input beats, decodes them into commands, two-entry queue.
// Depends on tpet_pkg.
module tpet_front #(
    parameter int NUM_CATEGORIES  = 8,
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tpet_pkg::t_in_item i_item,
    input  logic [7:0]        i_mute_mask,
    output logic              o_cmd_valid,
    input  logic              i_cmd_take,
    output tpet_pkg::t_cmd    o_cmd
);
    import tpet_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_fill, n_fill;
    t_cmd       w_cmd;
    logic       w_muted;
    logic       w_push, w_pop;

    always_comb begin
        w_cmd             = '0;
        w_cmd.category    = i_item.category;
        w_cmd.duration_ms = i_item.duration_ms;
        w_cmd.target_id   = i_item.target_id;
        w_cmd.elapsed_ms  = i_item.elapsed_ms;
        w_cmd.prio        = i_item.priority_req;
        if (int'(i_item.priority_req) >= PRIORITY_LEVELS) begin
            w_cmd.prio = 2'(PRIORITY_LEVELS - 1);
        end
        w_muted = (int'(i_item.category) >= NUM_CATEGORIES) ||
                  i_mute_mask[i_item.category];
        case (i_item.op)
            OP_POST:    w_cmd.kind = w_muted ? CMD_MUTED : CMD_POST;
            OP_DEL_ID:  w_cmd.kind = CMD_DEL_ID;
            OP_DEL_CAT: w_cmd.kind = CMD_DEL_CAT;
            OP_TICK:    w_cmd.kind = CMD_TICK;
            OP_DEL_ALL: w_cmd.kind = CMD_DEL_ALL;
            default:    w_cmd.kind = CMD_NOP;
        endcase
    end

    assign o_stall     = (r_fill == 2'd2);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_fill = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_fill <= n_fill;
        end
    end

endmodule

// ===== hdl/tpet_back.sv =====
// Back part: entry table in shifting registers, sequencer, output register.
// Depends on tpet_pkg.
module tpet_back #(
    parameter int CAPACITY = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [3:0]         i_max_active,
    input  logic               i_cmd_valid,
    output logic               o_cmd_take,
    input  tpet_pkg::t_cmd     i_cmd,
    output logic               o_valid,
    input  logic               i_stall,
    output tpet_pkg::t_out_item o_item,
    output tpet_pkg::t_bk_stat o_stat
);
    import tpet_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POST = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_MARK = 3'd3;
    localparam logic [2:0] S_REM  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]    r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    t_entry        r_tab [CAPACITY];
    t_entry        n_tab [CAPACITY];
    logic [CAPACITY-1:0] r_mark, n_mark;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [15:0]   r_next_id, n_next_id;
    logic          r_oval, n_oval;
    t_out_item     r_out, n_out;

    logic [CAPACITY-1:0] w_vld;
    logic          w_mk_found;
    logic [IDX_W-1:0] w_mk_idx, w_ev_idx, w_rm_idx;
    logic [1:0]    w_min_pr;
    logic [CNT_W-1:0] w_pos;
    logic          w_can_emit, w_evict, w_rm_en, w_ins_en;
    logic [CAPACITY-1:0] w_id_hit;
    t_entry        w_new;

    always_comb begin
        w_mk_found = 1'b0;
        w_mk_idx   = '0;
        w_min_pr   = 2'd3;
        w_ev_idx   = '0;
        w_pos      = r_cnt;
        for (int j = 0; j < CAPACITY; j++) begin
            w_vld[j]    = (j < int'(r_cnt));
            w_id_hit[j] = w_vld[j] && (r_tab[j].id == r_cmd.target_id);
            if (w_vld[j] && r_tab[j].prio < w_min_pr) w_min_pr = r_tab[j].prio;
        end
        for (int j = CAPACITY - 1; j >= 0; j--) begin
            if (r_mark[j]) begin
                w_mk_found = 1'b1;
                w_mk_idx   = IDX_W'(j);
            end
            if (w_vld[j] && r_tab[j].prio == w_min_pr) w_ev_idx = IDX_W'(j);
            if (w_vld[j] && r_tab[j].prio < r_cmd.prio) w_pos = CNT_W'(j);
        end
    end

    assign w_evict = (r_cnt != '0) &&
                     ((int'(r_cnt) >= int'(i_max_active)) || (int'(r_cnt) >= CAPACITY));
    assign w_can_emit = !r_oval || !i_stall;

    always_comb begin
        w_new.id           = r_next_id;
        w_new.category     = r_cmd.category;
        w_new.prio         = r_cmd.prio;
        w_new.persistent   = (r_cmd.duration_ms == 16'd0);
        w_new.remaining_ms = r_cmd.duration_ms;
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_tab      = r_tab;
        n_mark     = r_mark;
        n_cnt      = r_cnt;
        n_next_id  = r_next_id;
        n_oval     = r_oval && i_stall;
        n_out      = r_out;
        o_cmd_take = 1'b0;
        w_rm_en    = 1'b0;
        w_rm_idx   = '0;
        w_ins_en   = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_cmd_take = i_cmd_valid;
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    case (i_cmd.kind)
                        CMD_POST, CMD_MUTED: n_state = S_POST;
                        CMD_DEL_ID, CMD_DEL_CAT, CMD_TICK, CMD_DEL_ALL: n_state = S_MARK;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_POST: begin
                if (r_cmd.kind == CMD_MUTED) begin
                    if (w_can_emit) begin
                        n_oval  = 1'b1;
                        n_out   = '{EV_MUTED, 16'd0, 4'(r_cnt), 1'b0};
                        n_state = S_DONE;
                    end
                end else if (w_evict) begin
                    if (w_can_emit) begin
                        w_rm_en  = 1'b1;
                        w_rm_idx = w_ev_idx;
                        n_oval   = 1'b1;
                        n_out    = '{EV_EVICTED, r_tab[w_ev_idx].id,
                                     4'(r_cnt - 1'b1), 1'b0};
                        n_state  = S_INS;
                    end
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                if (w_can_emit) begin
                    w_ins_en  = 1'b1;
                    n_oval    = 1'b1;
                    n_out     = '{EV_POSTED, r_next_id, 4'(r_cnt + 1'b1), 1'b0};
                    n_next_id = (r_next_id == 16'hFFFF) ? 16'd1 : r_next_id + 16'd1;
                    n_state   = S_DONE;
                end
            end
            S_MARK: begin
                // dismiss by id marks only the first hit
                n_mark = w_id_hit & (~w_id_hit + 1'b1);
                for (int j = 0; j < CAPACITY; j++) begin
                    case (r_cmd.kind)
                        CMD_DEL_CAT: n_mark[j] = w_vld[j] &&
                                                 (r_tab[j].category == r_cmd.category);
                        CMD_DEL_ALL: n_mark[j] = w_vld[j];
                        CMD_TICK: begin
                            n_mark[j] = w_vld[j] && !r_tab[j].persistent &&
                                        (r_tab[j].remaining_ms <= r_cmd.elapsed_ms);
                            if (w_vld[j] && !r_tab[j].persistent && !n_mark[j]) begin
                                n_tab[j].remaining_ms = r_tab[j].remaining_ms -
                                                        r_cmd.elapsed_ms;
                            end
                        end
                        default: ;
                    endcase
                end
                n_state = S_REM;
            end
            S_REM: begin
                if (!w_mk_found) begin
                    n_state = S_DONE;
                end else if (w_can_emit) begin
                    w_rm_en  = 1'b1;
                    w_rm_idx = w_mk_idx;
                    n_oval   = 1'b1;
                    n_out    = '{(r_cmd.kind == CMD_TICK) ? EV_EXPIRED : EV_DISMISSED,
                                 r_tab[w_mk_idx].id, 4'(r_cnt - 1'b1), 1'b0};
                end
            end
            S_DONE: begin
                if (w_can_emit) begin
                    n_oval  = 1'b1;
                    n_out   = '{EV_DONE, 16'd0, 4'(r_cnt), 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_rm_en) begin
            for (int j = 0; j < CAPACITY - 1; j++) begin
                if (j >= int'(w_rm_idx)) begin
                    n_tab[j]  = r_tab[j + 1];
                    n_mark[j] = r_mark[j + 1];
                end
            end
            n_mark[CAPACITY - 1] = 1'b0;
            n_cnt = r_cnt - 1'b1;
        end
        if (w_ins_en) begin
            for (int j = 1; j < CAPACITY; j++) begin
                if (j > int'(w_pos)) n_tab[j] = r_tab[j - 1];
            end
            for (int j = 0; j < CAPACITY; j++) begin
                if (j == int'(w_pos)) n_tab[j] = w_new;
            end
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_tab <= n_tab;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mark    <= '0;
            r_cnt     <= '0;
            r_next_id <= 16'd1;
            r_oval    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mark    <= n_mark;
            r_cnt     <= n_cnt;
            r_next_id <= n_next_id;
            r_oval    <= n_oval;
        end
    end

    assign o_valid        = r_oval;
    assign o_item         = r_out;
    assign o_stat.busy    = (r_state != S_IDLE);
    assign o_stat.cnt_ovf = (int'(r_cnt) > CAPACITY);

endmodule

// ===== dv/timed_priority_entry_table_checker.sv =====
// Checker for the timed priority entry table: watches both channels, predicts result beats.
// Depends on tpet_pkg and on the config writes seen on the block's config port.
module timed_priority_entry_table_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_stall_in,
    input  tpet_pkg::t_in_item  i_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  tpet_pkg::t_out_item i_out_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tpet_pkg::*;

    localparam int CAP = 8;

    t_entry    table_q [CAP];
    int        live;
    logic [15:0] id_ctr;
    logic [3:0]  evict_at;
    logic [7:0]  muted_cats;
    t_out_item   want_q [$];

    assign o_pending = want_q.size();

    function automatic void push_event(logic [2:0] kind, logic [15:0] id, logic last);
        t_out_item r;
        r.event_kind = kind;
        r.event_id = id;
        r.active_count = 4'(live);
        r.last = last;
        want_q.insert(want_q.size(), r);
    endfunction

    function automatic void remove_at(int k);
        for (int j = k; j + 1 < live; j++) table_q[j] = table_q[j + 1];
        live--;
    endfunction

    function automatic void push_id_evict(int w);
        logic [15:0] vid;
        vid = table_q[w].id;
        remove_at(w);
        push_event(EV_EVICTED, vid, 1'b0);
    endfunction

    function automatic void predict_table(t_in_item it);
        int w;
        int pos;
        t_entry e;
        case (it.op)
            OP_POST: begin
                if (muted_cats[it.category]) begin
                    push_event(EV_MUTED, 16'd0, 1'b0);
                end else begin
                    e.id = id_ctr;
                    e.category = it.category;
                    e.prio = it.priority_req;
                    e.persistent = (it.duration_ms == 16'd0);
                    e.remaining_ms = it.duration_ms;
                    id_ctr = (id_ctr == 16'hFFFF) ? 16'd1 : id_ctr + 16'd1;
                    if (live > 0 && (live >= evict_at || live >= CAP)) begin
                        w = 0;
                        for (int k = 1; k < live; k++)
                            if (table_q[k].prio < table_q[w].prio) w = k;
                        push_id_evict(w);
                    end
                    pos = 0;
                    while (pos < live && table_q[pos].prio >= e.prio) pos++;
                    for (int k = live; k > pos; k--) table_q[k] = table_q[k - 1];
                    table_q[pos] = e;
                    live++;
                    push_event(EV_POSTED, e.id, 1'b0);
                end
            end
            OP_DEL_ID: begin
                for (int k = 0; k < live; k++) begin
                    if (table_q[k].id == it.target_id) begin
                        remove_at(k);
                        push_event(EV_DISMISSED, it.target_id, 1'b0);
                        break;
                    end
                end
            end
            OP_DEL_CAT: begin
                w = 0;
                while (w < live) begin
                    if (table_q[w].category == it.category) begin
                        e = table_q[w];
                        remove_at(w);
                        push_event(EV_DISMISSED, e.id, 1'b0);
                    end else w++;
                end
            end
            OP_TICK: begin
                w = 0;
                while (w < live) begin
                    if (!table_q[w].persistent && table_q[w].remaining_ms <= it.elapsed_ms) begin
                        e = table_q[w];
                        remove_at(w);
                        push_event(EV_EXPIRED, e.id, 1'b0);
                    end else begin
                        if (!table_q[w].persistent)
                            table_q[w].remaining_ms -= it.elapsed_ms;
                        w++;
                    end
                end
            end
            OP_DEL_ALL: begin
                while (live > 0) begin
                    e = table_q[0];
                    remove_at(0);
                    push_event(EV_DISMISSED, e.id, 1'b0);
                end
            end
            default: ;
        endcase
        push_event(EV_DONE, 16'd0, 1'b1);
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            live = 0;
            id_ctr = 16'd1;
            evict_at = 4'd5;
            muted_cats = 8'd0;
            o_errors <= 0;
            want_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_ACTIVE) evict_at = i_cfg_data[3:0];
                else muted_cats = i_cfg_data;
            end
            if (i_valid && !i_stall_in) predict_table(i_item);
            if (i_out_valid && !i_out_stall) begin
                if (want_q.size() == 0) begin
                    $display("%0t: unexpected beat, actual %p", $time, i_out_item);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_item = want_q.pop_front();
                    if (exp_item !== i_out_item) begin
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $time, exp_item, i_out_item);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/timed_priority_entry_table_test.sv =====
// Testbench top for the timed priority entry table: drives items, config and output stalls.
// Depends on tpet_pkg, timed_priority_entry_table and timed_priority_entry_table_checker.
module timed_priority_entry_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tpet_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;
    logic      i_cfg_we = 1'b0;
    logic      i_cfg_index = 1'b0;
    logic [7:0] i_cfg_data = 8'd0;
    int        err_cnt;
    int        pending;
    bit        calm = 1'b0;
    bit        hold_out = 1'b0;

    timed_priority_entry_table uut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .o_valid, .i_stall, .o_item, .i_cfg_we, .i_cfg_index, .i_cfg_data
    );

    timed_priority_entry_table_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_item,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_item(o_item),
        .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_errors(err_cnt), .o_pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // output stalls: random, none in calm stretches, solid during hold-off
    always @(posedge i_clk) begin
        i_stall <= hold_out || (!calm && $urandom_range(99) < 15);
    end

    // valid stays up after the beat is taken; the next call may drop it, drain_idle drops it
    task automatic send_beat(t_in_item it);
        while (!calm && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic t_in_item make_op(logic [2:0] op, logic [2:0] cat, logic [1:0] pr,
                                         logic [15:0] dur, logic [15:0] tid,
                                         logic [15:0] el);
        t_in_item it;
        it.op = op; it.category = cat; it.priority_req = pr;
        it.duration_ms = dur; it.target_id = tid; it.elapsed_ms = el;
        return it;
    endfunction

    function automatic t_in_item random_op();
        t_in_item it;
        int r;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        r = $urandom_range(99);
        if (r < 45) it.op = OP_POST;
        else if (r < 58) it.op = OP_DEL_ID;
        else if (r < 68) it.op = OP_DEL_CAT;
        else if (r < 88) it.op = OP_TICK;
        else if (r < 93) it.op = OP_DEL_ALL;
        else it.op = 3'($urandom_range(7, 5));
        if ($urandom_range(3) != 0) it.target_id = 16'($urandom_range(120));
        if ($urandom_range(2) != 0) it.duration_ms = 16'($urandom_range(2000));
        if ($urandom_range(3) == 0) it.duration_ms = 16'd0;
        if ($urandom_range(2) != 0) it.elapsed_ms = 16'($urandom_range(600));
        return it;
    endfunction

    task automatic drain_idle();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] masks [4];
        logic [3:0] maxes [4];
        masks = '{8'h00, 8'hFF, 8'hA5, 8'h12};
        maxes = '{4'd8, 4'd1, 4'd0, 4'd15};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of each field and op
        calm = 1'b1;
        send_beat(make_op(OP_POST, 3'd0, 2'd0, 16'd0, 16'd0, 16'd0));
        send_beat(make_op(OP_POST, 3'd7, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_beat(make_op(OP_POST, 3'd3, 2'd1, 16'd10, 16'd0, 16'd0));
        send_beat(make_op(OP_POST, 3'd3, 2'd3, 16'd5, 16'd0, 16'd0));
        send_beat(make_op(OP_POST, 3'd5, 2'd2, 16'd20, 16'd0, 16'd0));
        send_beat(make_op(OP_POST, 3'd1, 2'd0, 16'd1, 16'd0, 16'd0));
        send_beat(make_op(OP_POST, 3'd2, 2'd3, 16'd0, 16'd0, 16'd0)); // eviction at 5
        send_beat(make_op(OP_TICK, 3'd0, 2'd0, 16'd0, 16'd0, 16'd5));   // equal expires
        send_beat(make_op(OP_DEL_ID, 3'd0, 2'd0, 16'd0, 16'd3, 16'd0));
        send_beat(make_op(OP_DEL_ID, 3'd0, 2'd0, 16'd0, 16'd999, 16'd0)); // missing id
        send_beat(make_op(OP_DEL_CAT, 3'd7, 2'd0, 16'd0, 16'd0, 16'd0));
        send_beat(make_op(3'd5, 3'd0, 2'd0, 16'd0, 16'd0, 16'd0));
        send_beat(make_op(3'd7, 3'd7, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_beat(make_op(OP_DEL_ALL, 3'd0, 2'd0, 16'd0, 16'd0, 16'd0));
        calm = 1'b0;

        // random phases across register settings; hold-off during phase 0
        for (int ph = 0; ph < 4; ph++) begin
            drain_idle();
            write_reg(CFG_MAX_ACTIVE, {4'd0, maxes[ph]});
            write_reg(CFG_MUTE_MASK, masks[ph]);
            if (ph == 0) begin
                fork
                    begin
                        hold_out = 1'b1;
                        repeat (300) @(posedge i_clk);
                        hold_out = 1'b0;
                    end
                join_none
            end
            if (ph == 2) calm = 1'b1;
            for (int n = 0; n < 85; n++) begin
                if (ph == 2 && n == 40) calm = 1'b0;
                send_beat(random_op());
            end
        end

        drain_idle();
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
